[design/lift_phase_detector_macros.svh]
// ----------------------------------------------------------------------------
// Lift phase detector assertion macros
// Immediate-style wrappers around concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef LIFT_PHASE_DETECTOR_MACROS_SVH
`define LIFT_PHASE_DETECTOR_MACROS_SVH
`ifndef NO_ASSERTIONS
`define LPD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define LPD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define LPD_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define LPD_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

[design/lpd_pkg.sv]
// ----------------------------------------------------------------------------
// Lift phase detector package
// Shared types, register indexes and phase codes.
// ----------------------------------------------------------------------------
`default_nettype none
package lpd_pkg;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 32;
    localparam int unsigned DIV_NUM_W = 64;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_VEL_DEADBAND = 3'd0,
        REG_KNEE_LOCKOUT = 3'd1,
        REG_HOLD_COUNT   = 3'd2,
        REG_COEF_B0      = 3'd3,
        REG_COEF_B1      = 3'd4,
        REG_COEF_B2      = 3'd5,
        REG_COEF_A1      = 3'd6,
        REG_COEF_A2      = 3'd7
    } reg_idx_t;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_DESC   = 3'd1,
        PH_BOTTOM = 3'd2,
        PH_ASC    = 3'd3,
        PH_STICK  = 3'd4
    } phase_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MAC_V,
        ST_MAC_Y,
        ST_VDIV_START,
        ST_VDIV_WAIT,
        ST_ADIV_START,
        ST_ADIV_WAIT,
        ST_PHASE,
        ST_OUT
    } seq_state_t;

    // Control and status between the sequencer and the divider.
    typedef struct packed {
        logic start;
    } div_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_sts_t;
endpackage
`default_nettype wire

[design/lpd_if.sv]
// ----------------------------------------------------------------------------
// Lift phase detector channels
// Valid/ready interfaces for frames, results and register writes.
// ----------------------------------------------------------------------------
`default_nettype none
interface lpd_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] stamp_ms;
    logic signed [15:0] hip_height;
    logic [11:0] knee_deg;
    modport source (output valid, stamp_ms, hip_height, knee_deg, input ready);
    modport sink (input valid, stamp_ms, hip_height, knee_deg, output ready);
endinterface

interface lpd_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  phase;
    logic signed [23:0] velocity;
    logic signed [31:0] accel;
    logic [31:0] phase_start_ms;
    modport source (output valid, phase, velocity, accel, phase_start_ms, input ready);
    modport sink (input valid, phase, velocity, accel, phase_start_ms, output ready);
endinterface

interface lpd_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [31:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

[design/lpd_mac.sv]
// ----------------------------------------------------------------------------
// Lift phase detector serial multiply-accumulate
// Sums three products of a 16-bit coefficient and a 24-bit sample, one
// multiplier bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module lpd_mac
    import lpd_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic signed [15:0] c0,
    input  wire logic signed [15:0] c1,
    input  wire logic signed [15:0] c2,
    input  wire logic signed [23:0] s0,
    input  wire logic signed [23:0] s1,
    input  wire logic signed [23:0] s2,
    output logic                    done,
    output logic signed [47:0]      sum
);
    logic [4:0]         cnt_reg, cnt_next;
    logic               run_reg, run_next;
    logic [15:0]        m0_reg, m1_reg, m2_reg;
    logic signed [47:0] acc_reg, acc_next;
    logic signed [47:0] a0_reg, a1_reg, a2_reg;
    logic signed [47:0] term;

    // Booth-free signed serial multiply: the top coefficient bit has weight -2^15.
    always_comb
    begin
        term = 48'sd0;
        if (m0_reg[0]) term = term + a0_reg;
        if (m1_reg[0]) term = term + a1_reg;
        if (m2_reg[0]) term = term + a2_reg;
        run_next = run_reg;
        cnt_next = cnt_reg;
        acc_next = acc_reg;
        if (start)
        begin
            run_next = 1'b1;
            cnt_next = 5'd0;
            acc_next = 48'sd0;
        end
        else if (run_reg)
        begin
            acc_next = (cnt_reg == 5'd15) ? acc_reg - term : acc_reg + term;
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd15) run_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            cnt_reg <= 5'd0;
        end
        else
        begin
            run_reg <= run_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        if (start)
        begin
            m0_reg <= c0;
            m1_reg <= c1;
            m2_reg <= c2;
            a0_reg <= 48'(s0);
            a1_reg <= 48'(s1);
            a2_reg <= 48'(s2);
        end
        else if (run_reg)
        begin
            m0_reg <= m0_reg >> 1;
            m1_reg <= m1_reg >> 1;
            m2_reg <= m2_reg >> 1;
            a0_reg <= a0_reg <<< 1;
            a1_reg <= a1_reg <<< 1;
            a2_reg <= a2_reg <<< 1;
        end
    end

    // A new start aborts a pass that is still running, so it never reports done.
    assign done = run_reg && !start && (cnt_reg == 5'd15);
    assign sum  = acc_next;
endmodule
`default_nettype wire

[design/lpd_div.sv]
// ----------------------------------------------------------------------------
// Lift phase detector serial divider
// Signed restoring division truncating toward zero, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module lpd_div
    import lpd_pkg::*;
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire div_ctl_t                      ctl,
    input  wire logic signed [DIV_NUM_W-1:0]   num,
    input  wire logic [31:0]                   den,
    output div_sts_t                           sts,
    output logic signed [DIV_NUM_W-1:0]        quo
);
    localparam int unsigned CW = $clog2(DIV_NUM_W);
    logic [CW-1:0]          cnt_reg, cnt_next;
    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    logic                   neg_reg;
    logic [DIV_NUM_W-1:0]   q_reg, q_next;
    logic [31:0]            r_reg, r_next;
    logic [31:0]            d_reg;
    logic [32:0]            trial;
    logic [32:0]            sub;

    always_comb
    begin
        trial = {r_reg, q_reg[DIV_NUM_W-1]};
        sub = trial - {1'b0, d_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next = cnt_reg;
        q_next = q_reg;
        r_next = r_reg;
        if (ctl.start)
        begin
            busy_next = 1'b1;
            cnt_next = '0;
            q_next = num[DIV_NUM_W-1] ? DIV_NUM_W'(-num) : DIV_NUM_W'(num);
            r_next = '0;
        end
        else if (busy_reg)
        begin
            if (!sub[32])
            begin
                r_next = sub[31:0];
                q_next = {q_reg[DIV_NUM_W-2:0], 1'b1};
            end
            else
            begin
                r_next = trial[31:0];
                q_next = {q_reg[DIV_NUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + CW'(1);
            if (cnt_reg == CW'(DIV_NUM_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        if (ctl.start)
        begin
            d_reg   <= den;
            neg_reg <= num[DIV_NUM_W-1];
        end
    end

    assign sts.busy = busy_reg;
    assign sts.done = done_reg;
    assign quo = neg_reg ? -$signed(q_reg) : $signed(q_reg);
endmodule
`default_nettype wire

[design/lift_phase_detector.sv]
// ----------------------------------------------------------------------------
// Lift phase detector
// Smooths hip height, derives velocity and acceleration, tracks lift phase.
// ----------------------------------------------------------------------------
// Usage: frames enter on in_ch (stamp_ms, hip_height, knee_deg) and each one
// yields exactly one word on out_ch (phase, velocity, accel, phase_start_ms).
// Registers are written on cfg_ch with an index and 32-bit data; write only
// while no frame is in flight.
// One frame at a time is processed. The two biquad sums run on a bit-serial
// multiply-accumulate unit, and the two divisions by the frame interval run
// on a bit-serial divider. With an interval under 2 ms the divisions are
// skipped, and the first frame after reset skips both the filter and the
// divisions. A new frame can be accepted in the cycle after the previous
// result is loaded into the output register.
// The result sits in an output register. A stalled receiver keeps it there
// while the next frame is still accepted and processed; that frame then
// waits in its last step until the held word is taken. Reset clears the
// filter history, the phase (idle) and restores the register defaults.
// ----------------------------------------------------------------------------
`default_nettype none
`include "lift_phase_detector_macros.svh"
module lift_phase_detector
    import lpd_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    lpd_in_if.sink   in_ch,
    lpd_out_if.source out_ch,
    lpd_cfg_if.sink  cfg_ch
);
    logic [22:0]        db_reg;
    logic [11:0]        lock_reg;
    logic [7:0]         hold_reg;
    logic signed [15:0] b0_reg, b1_reg, b2_reg, a1_reg, a2_reg;

    seq_state_t state_reg, state_next;
    logic               have_prev_reg;
    logic signed [15:0] prev_h_reg;
    logic signed [23:0] prev_v_reg;
    logic signed [31:0] prev_a_reg;
    logic [31:0]        prev_st_reg;
    logic signed [23:0] d0_reg, d1_reg;
    phase_t             phase_reg;
    logic [7:0]         hcnt_reg;
    logic [31:0]        entry_reg;

    logic [31:0]        st_reg;
    logic signed [15:0] x_reg;
    logic [11:0]        knee_reg;
    logic signed [23:0] v_reg;
    logic signed [15:0] y_reg;
    logic signed [23:0] vel_reg;
    logic signed [31:0] acc_reg;
    logic [31:0]        dt_reg;

    logic               ov_reg;
    logic [2:0]         o_ph_reg;
    logic signed [23:0] o_v_reg;
    logic signed [31:0] o_a_reg;
    logic [31:0]        o_st_reg;

    logic               in_acc, out_acc, out_load;
    logic               mac_start, mac_done;
    logic signed [15:0] mc0, mc1, mc2;
    logic signed [23:0] ms0, ms1, ms2;
    logic signed [47:0] mac_sum;
    logic signed [47:0] rnd;
    logic signed [33:0] v_wide;
    div_ctl_t           dctl;
    div_sts_t           dsts;
    logic signed [DIV_NUM_W-1:0] dnum, dquo;
    logic signed [31:0] dt_s;

    assign in_acc  = in_ch.valid && in_ch.ready;
    assign out_acc = out_ch.valid && out_ch.ready;
    assign in_ch.ready = (state_reg == ST_IDLE);
    assign cfg_ch.ready = 1'b1;
    // The output register takes a new word once it is empty or being emptied.
    assign out_load = (state_reg == ST_OUT) && (!ov_reg || out_acc);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            db_reg   <= 23'd205;
            lock_reg <= 12'd2560;
            hold_reg <= 8'd3;
            b0_reg   <= 16'sd1599;
            b1_reg   <= 16'sd3200;
            b2_reg   <= 16'sd1599;
            a1_reg   <= -16'sd15447;
            a2_reg   <= 16'sd5461;
        end
        else if (cfg_ch.valid)
        begin
            unique case (reg_idx_t'(cfg_ch.index))
                REG_VEL_DEADBAND: db_reg <= cfg_ch.data[22:0];
                REG_KNEE_LOCKOUT: lock_reg <= cfg_ch.data[11:0];
                REG_HOLD_COUNT:   hold_reg <= cfg_ch.data[7:0];
                REG_COEF_B0:      b0_reg <= cfg_ch.data[15:0];
                REG_COEF_B1:      b1_reg <= cfg_ch.data[15:0];
                REG_COEF_B2:      b2_reg <= cfg_ch.data[15:0];
                REG_COEF_A1:      a1_reg <= cfg_ch.data[15:0];
                REG_COEF_A2:      a2_reg <= cfg_ch.data[15:0];
                default:          ;
            endcase
        end
    end

    // The feedback pass computes a1*d0 + a2*d1; the forward pass b0*v + b1*d0 + b2*d1.
    always_comb
    begin
        if (state_reg == ST_MAC_V)
        begin
            mc0 = a1_reg; mc1 = a2_reg; mc2 = 16'sd0;
            ms0 = d0_reg; ms1 = d1_reg; ms2 = 24'sd0;
        end
        else
        begin
            mc0 = b0_reg; mc1 = b1_reg; mc2 = b2_reg;
            ms0 = v_reg;  ms1 = d0_reg; ms2 = d1_reg;
        end
    end

    logic mac_kick_reg;
    assign mac_start = mac_kick_reg;

    lpd_mac u_mac (
        .clk(clk), .rst_n(rst_n), .start(mac_start),
        .c0(mc0), .c1(mc1), .c2(mc2), .s0(ms0), .s1(ms1), .s2(ms2),
        .done(mac_done), .sum(mac_sum)
    );

    assign rnd = (mac_sum + 48'sd8192) >>> 14;
    assign v_wide = 34'(x_reg) - 34'(rnd);
    assign dt_s = $signed(st_reg - prev_st_reg);

    assign dctl.start = (state_reg == ST_VDIV_START) || (state_reg == ST_ADIV_START);
    always_comb
    begin
        if (state_reg == ST_VDIV_START)
            dnum = DIV_NUM_W'((34'(y_reg) - 34'(prev_h_reg)) * 34'sd1000);
        else
            dnum = DIV_NUM_W'((44'(vel_reg) - 44'(prev_v_reg)) * 44'sd1000);
    end

    lpd_div u_div (
        .clk(clk), .rst_n(rst_n), .ctl(dctl), .num(dnum), .den(dt_reg),
        .sts(dsts), .quo(dquo)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:       if (in_acc) state_next = ST_MAC_V;
            ST_MAC_V:
            begin
                if (!have_prev_reg) state_next = ST_PHASE;
                else if (mac_done) state_next = ST_MAC_Y;
            end
            ST_MAC_Y:
            begin
                if (mac_done)
                    state_next = (dt_s >= 32'sd2) ? ST_VDIV_START : ST_PHASE;
            end
            ST_VDIV_START: state_next = ST_VDIV_WAIT;
            ST_VDIV_WAIT:  if (dsts.done) state_next = ST_ADIV_START;
            ST_ADIV_START: state_next = ST_ADIV_WAIT;
            ST_ADIV_WAIT:  if (dsts.done) state_next = ST_PHASE;
            ST_PHASE:      state_next = ST_OUT;
            ST_OUT:        if (out_load) state_next = ST_IDLE;
            default:       state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Phase decision and advancing of the hold counter.
    logic       adv;
    phase_t     tgt;
    logic [7:0] hinc;
    logic signed [24:0] vel_e, db_e, vabs;
    always_comb
    begin
        vel_e = 25'(vel_reg);
        db_e  = $signed({2'b00, db_reg});
        vabs  = vel_e[24] ? -vel_e : vel_e;
        adv = 1'b0;
        tgt = PH_IDLE;
        unique case (phase_reg)
            PH_DESC:
            begin
                adv = (vel_e >= -db_e) && (acc_reg > 32'sd0);
                tgt = PH_BOTTOM;
            end
            PH_BOTTOM:
            begin
                adv = vel_e > db_e;
                tgt = PH_ASC;
            end
            PH_ASC:
            begin
                if (vel_e < db_e && knee_reg < lock_reg)
                begin
                    adv = 1'b1; tgt = PH_STICK;
                end
                else if (knee_reg >= lock_reg && vabs < db_e)
                begin
                    adv = 1'b1; tgt = PH_IDLE;
                end
            end
            PH_STICK:
            begin
                if (vel_e > db_e)
                begin
                    adv = 1'b1; tgt = PH_ASC;
                end
                else if (knee_reg >= lock_reg)
                begin
                    adv = 1'b1; tgt = PH_IDLE;
                end
            end
            default:
            begin
                adv = (vel_e < -db_e) && (knee_reg < lock_reg);
                tgt = PH_DESC;
            end
        endcase
        hinc = hcnt_reg + 8'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_prev_reg <= 1'b0;
            prev_h_reg    <= '0;
            prev_v_reg    <= '0;
            prev_a_reg    <= '0;
            prev_st_reg   <= '0;
            d0_reg        <= '0;
            d1_reg        <= '0;
            phase_reg     <= PH_IDLE;
            hcnt_reg      <= '0;
            entry_reg     <= '0;
            ov_reg        <= 1'b0;
            mac_kick_reg  <= 1'b0;
        end
        else
        begin
            mac_kick_reg <= (in_acc) || (state_reg == ST_MAC_V && mac_done);
            if (out_load) ov_reg <= 1'b1;
            else if (out_acc) ov_reg <= 1'b0;
            if (state_reg == ST_MAC_Y && mac_done)
            begin
                d1_reg <= d0_reg;
                d0_reg <= v_reg;
            end
            if (state_reg == ST_PHASE)
            begin
                have_prev_reg <= 1'b1;
                prev_h_reg    <= y_reg;
                prev_v_reg    <= vel_reg;
                prev_a_reg    <= acc_reg;
                prev_st_reg   <= st_reg;
                if (adv)
                begin
                    if (hinc >= hold_reg)
                    begin
                        phase_reg <= tgt;
                        entry_reg <= st_reg;
                        hcnt_reg  <= '0;
                    end
                    else
                        hcnt_reg <= hinc;
                end
                else
                    hcnt_reg <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            st_reg   <= in_ch.stamp_ms;
            x_reg    <= in_ch.hip_height;
            knee_reg <= in_ch.knee_deg;
        end
        if (state_reg == ST_MAC_V)
        begin
            if (!have_prev_reg)
            begin
                y_reg   <= x_reg;
                vel_reg <= '0;
                acc_reg <= '0;
            end
            else if (mac_done)
            begin
                if (v_wide > 34'sd8388607) v_reg <= 24'sd8388607;
                else if (v_wide < -34'sd8388608) v_reg <= -24'sd8388608;
                else v_reg <= v_wide[23:0];
            end
        end
        if (state_reg == ST_MAC_Y && mac_done)
        begin
            if (rnd > 48'sd32767) y_reg <= 16'sd32767;
            else if (rnd < -48'sd32768) y_reg <= -16'sd32768;
            else y_reg <= rnd[15:0];
            dt_reg  <= dt_s;
            vel_reg <= prev_v_reg;
            acc_reg <= prev_a_reg;
        end
        if (state_reg == ST_VDIV_WAIT && dsts.done)
        begin
            if (dquo > 64'sd8388607) vel_reg <= 24'sd8388607;
            else if (dquo < -64'sd8388608) vel_reg <= -24'sd8388608;
            else vel_reg <= dquo[23:0];
        end
        if (state_reg == ST_ADIV_WAIT && dsts.done)
        begin
            if (dquo > 64'sd2147483647) acc_reg <= 32'sh7fffffff;
            else if (dquo < -64'sd2147483648) acc_reg <= 32'sh80000000;
            else acc_reg <= dquo[31:0];
        end
        if (out_load)
        begin
            o_ph_reg <= phase_reg;
            o_v_reg  <= vel_reg;
            o_a_reg  <= acc_reg;
            o_st_reg <= entry_reg;
        end
    end

    assign out_ch.valid          = ov_reg;
    assign out_ch.phase          = o_ph_reg;
    assign out_ch.velocity       = o_v_reg;
    assign out_ch.accel          = o_a_reg;
    assign out_ch.phase_start_ms = o_st_reg;

    `LPD_ASSERT_IMPL(a_no_accept_busy, clk, rst_n, state_reg != ST_IDLE, !in_ch.ready)
    `LPD_ASSERT_NEXT(a_out_after_phase, clk, rst_n, state_reg == ST_OUT, ov_reg)
    `LPD_ASSERT_IMPL(a_div_idle, clk, rst_n, dctl.start, !dsts.busy)
    `LPD_ASSERT_IMPL(a_phase_legal, clk, rst_n, 1'b1, phase_reg <= PH_STICK)
endmodule
`default_nettype wire

[tb/sv/lift_phase_detector_test.sv]
// ----------------------------------------------------------------------------
// Lift phase detector testbench
// Drives camera frames and register writes into the detector, predicts every
// result word with a cycle-free model of the filter, the differentiator and
// the phase machine, and compares each word that comes out field by field.
// ----------------------------------------------------------------------------
`default_nettype none
module lift_phase_detector_test;
    import lpd_pkg::*;

    // One predicted result word.
    typedef struct {
        logic [2:0]  phase;
        logic [23:0] velocity;
        logic [31:0] accel;
        logic [31:0] phase_start_ms;
    } lift_word_t;

    logic clk;
    logic rst_n;

    lpd_in_if  in_ch ();
    lpd_out_if out_ch ();
    lpd_cfg_if cfg_ch ();

    lift_phase_detector u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg_ch (cfg_ch)
    );

    // Words still to arrive, oldest first.
    lift_word_t pending_words[$];
    int         error_count;

    // Idle percentages of the sender and the receiver for the current phase.
    int src_idle_pct;
    int snk_stall_pct;

    // Mirror of the register file.
    longint deadband_q;
    longint lockout_q;
    int     hold_q;
    longint b0_q, b1_q, b2_q, a1_q, a2_q;

    // Mirror of the detector state.
    bit          seen_frame;
    longint      last_height;
    longint      last_vel;
    longint      last_acc;
    logic [31:0] last_stamp;
    longint      delay0, delay1;
    phase_t      lift_phase;
    logic [7:0]  qual_count;
    logic [31:0] phase_entry;

    // Stimulus bookkeeping for the lift generator.
    logic [31:0] gen_stamp;
    int          gen_height;

    // ------------------------------------------------------------------------
    // Clock and watchdog.
    // ------------------------------------------------------------------------
    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    initial
    begin
        #40000000;
        $display("FAIL lift_phase_detector");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Arithmetic helpers of the predictor.
    // ------------------------------------------------------------------------
    function automatic longint clamp_signed(longint v, int w);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (w - 1)) - 1;
        lo = -hi - 1;
        if (v > hi)
            return hi;
        if (v < lo)
            return lo;
        return v;
    endfunction

    // Q2.14 product sum back to integer, rounding half up.
    function automatic longint round_q14(longint v);
        return (v + 8192) >>> 14;
    endfunction

    function automatic void restore_defaults();
        deadband_q  = 205;
        lockout_q   = 2560;
        hold_q      = 3;
        b0_q        = 1599;
        b1_q        = 3200;
        b2_q        = 1599;
        a1_q        = -15447;
        a2_q        = 5461;
        seen_frame  = 1'b0;
        last_height = 0;
        last_vel    = 0;
        last_acc    = 0;
        last_stamp  = '0;
        delay0      = 0;
        delay1      = 0;
        lift_phase  = PH_IDLE;
        qual_count  = '0;
        phase_entry = '0;
    endfunction

    // A qualifying frame: after enough in a row the phase moves to target.
    function automatic void count_toward(phase_t target, logic [31:0] stamp);
        qual_count = qual_count + 8'd1;
        if (int'(qual_count) >= hold_q)
        begin
            lift_phase  = target;
            phase_entry = stamp;
            qual_count  = '0;
        end
    endfunction

    // Works out the word that one accepted frame must produce.
    function automatic lift_word_t predict_frame(logic [31:0] stamp,
                                                 logic signed [15:0] hip,
                                                 logic [11:0] knee_in);
        lift_word_t w;
        longint     x, y, v, vel, acc, dt, knee, db, vel_abs;
        x    = hip;
        knee = knee_in;
        db   = deadband_q;
        vel  = 0;
        acc  = 0;
        if (!seen_frame)
        begin
            // The first frame bypasses the filter entirely.
            y = x;
        end
        else
        begin
            v = clamp_signed(x - round_q14(a1_q * delay0 + a2_q * delay1), 24);
            y = clamp_signed(round_q14(b0_q * v + b1_q * delay0 + b2_q * delay1), 16);
            delay1 = delay0;
            delay0 = v;
            dt = longint'($signed(stamp - last_stamp));
            if (dt >= 2)
            begin
                vel = clamp_signed(((y - last_height) * 1000) / dt, 24);
                acc = clamp_signed(((vel - last_vel) * 1000) / dt, 32);
            end
            else
            begin
                // Short, zero or backward interval: hold the last derivatives.
                vel = last_vel;
                acc = last_acc;
            end
        end
        seen_frame  = 1'b1;
        last_height = y;
        last_vel    = vel;
        last_acc    = acc;
        last_stamp  = stamp;
        vel_abs     = (vel < 0) ? -vel : vel;

        case (lift_phase)
            PH_DESC:
                if (vel >= -db && acc > 0)
                    count_toward(PH_BOTTOM, stamp);
                else
                    qual_count = '0;
            PH_BOTTOM:
                if (vel > db)
                    count_toward(PH_ASC, stamp);
                else
                    qual_count = '0;
            PH_ASC:
                if (vel < db && knee < lockout_q)
                    count_toward(PH_STICK, stamp);
                else if (knee >= lockout_q && vel_abs < db)
                    count_toward(PH_IDLE, stamp);
                else
                    qual_count = '0;
            PH_STICK:
                if (vel > db)
                    count_toward(PH_ASC, stamp);
                else if (knee >= lockout_q)
                    count_toward(PH_IDLE, stamp);
                else
                    qual_count = '0;
            default:
                if (vel < -db && knee < lockout_q)
                    count_toward(PH_DESC, stamp);
                else
                    qual_count = '0;
        endcase

        w.phase          = lift_phase;
        w.velocity       = vel[23:0];
        w.accel          = acc[31:0];
        w.phase_start_ms = phase_entry;
        return w;
    endfunction

    // ------------------------------------------------------------------------
    // Result checker. Handshake values are sampled as they stood at the edge,
    // and ready is redrawn for the next cycle with a nonblocking assignment.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        lift_word_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (pending_words.size() == 0)
            begin
                $error("result word with no frame pending");
                error_count++;
            end
            else
            begin
                want = pending_words.pop_front();
                if (out_ch.phase !== want.phase)
                begin
                    $error("phase: expected %0d, got %0d", want.phase, out_ch.phase);
                    error_count++;
                end
                if (out_ch.velocity !== want.velocity)
                begin
                    $error("velocity: expected %0d, got %0d",
                           $signed(want.velocity), out_ch.velocity);
                    error_count++;
                end
                if (out_ch.accel !== want.accel)
                begin
                    $error("accel: expected %0d, got %0d",
                           $signed(want.accel), out_ch.accel);
                    error_count++;
                end
                if (out_ch.phase_start_ms !== want.phase_start_ms)
                begin
                    $error("phase_start_ms: expected %0d, got %0d",
                           want.phase_start_ms, out_ch.phase_start_ms);
                    error_count++;
                end
            end
        end
        out_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
    end

    // ------------------------------------------------------------------------
    // Shared driving tasks.
    // ------------------------------------------------------------------------

    // Offers one frame and returns once it is accepted; the prediction is
    // made at the accepting edge so that it follows the block's own order.
    task automatic send_frame(logic [31:0] stamp, logic signed [15:0] hip,
                              logic [11:0] knee);
        int gap;
        if ($urandom_range(99) < src_idle_pct)
        begin
            gap = $urandom_range(8, 1);
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.stamp_ms   <= stamp;
        in_ch.hip_height <= hip;
        in_ch.knee_deg   <= knee;
        do
            @(posedge clk);
        while (!in_ch.ready);
        pending_words.insert(pending_words.size(), predict_frame(stamp, hip, knee));
    endtask

    task automatic stop_sending();
        in_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    // Waits until every predicted word has arrived, then lets the block
    // settle for about one frame time so that it is truly idle.
    task automatic drain_words();
        stop_sending();
        while (pending_words.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    // Writes one register; the upper data bits are junk that must be ignored.
    task automatic write_reg(reg_idx_t idx, longint value);
        logic [31:0] word;
        word = $urandom();
        case (idx)
            REG_VEL_DEADBAND:
            begin
                word[22:0] = value[22:0];
                deadband_q = value[22:0];
            end
            REG_KNEE_LOCKOUT:
            begin
                word[11:0] = value[11:0];
                lockout_q  = value[11:0];
            end
            REG_HOLD_COUNT:
            begin
                word[7:0] = value[7:0];
                hold_q    = int'(value[7:0]);
            end
            default:
            begin
                word[15:0] = value[15:0];
                case (idx)
                    REG_COEF_B0: b0_q = longint'($signed(value[15:0]));
                    REG_COEF_B1: b1_q = longint'($signed(value[15:0]));
                    REG_COEF_B2: b2_q = longint'($signed(value[15:0]));
                    REG_COEF_A1: a1_q = longint'($signed(value[15:0]));
                    default:     a2_q = longint'($signed(value[15:0]));
                endcase
            end
        endcase
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= word;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic write_all(longint db, longint lock, longint hold, longint b0,
                             longint b1, longint b2, longint a1, longint a2);
        drain_words();
        write_reg(REG_VEL_DEADBAND, db);
        write_reg(REG_KNEE_LOCKOUT, lock);
        write_reg(REG_HOLD_COUNT, hold);
        write_reg(REG_COEF_B0, b0);
        write_reg(REG_COEF_B1, b1);
        write_reg(REG_COEF_B2, b2);
        write_reg(REG_COEF_A1, a1);
        write_reg(REG_COEF_A2, a2);
    endtask

    // Next frame time: mostly a camera interval, sometimes a short, repeated
    // or backward stamp to exercise the held-derivative case.
    function automatic logic [31:0] next_stamp();
        int r;
        r = $urandom_range(99);
        if (r < 4)
            gen_stamp = gen_stamp + $urandom_range(1, 0);
        else if (r < 6)
            gen_stamp = gen_stamp - $urandom_range(50, 1);
        else if (r < 8)
            gen_stamp = gen_stamp + $urandom_range(5000, 2);
        else
            gen_stamp = gen_stamp + $urandom_range(40, 25);
        return gen_stamp;
    endfunction

    function automatic logic signed [15:0] step_height(int delta);
        gen_height = gen_height + delta + $urandom_range(6) - 3;
        if (gen_height > 32767)
            gen_height = 32767;
        if (gen_height < -32768)
            gen_height = -32768;
        return gen_height[15:0];
    endfunction

    // Sends about n frames: mostly whole repetitions (stand, descend, bottom,
    // ascend with an occasional sticking stretch, lock out), with bursts of
    // unrelated random frames mixed in.
    task automatic run_lifts(int n);
        int sent;
        int k;
        int rate;
        int reps;
        sent = 0;
        while (sent < n)
        begin
            if ($urandom_range(99) < 80)
            begin
                rate = $urandom_range(300, 15);
                reps = $urandom_range(5, 2);
                for (k = 0; k < reps; k++)
                    send_frame(next_stamp(), step_height(0),
                               12'($urandom_range(4095, 2600)));
                sent += reps;
                reps = $urandom_range(30, 8);
                for (k = 0; k < reps; k++)
                    send_frame(next_stamp(), step_height(-rate),
                               12'($urandom_range(2400, 900)));
                sent += reps;
                reps = $urandom_range(8, 3);
                for (k = 0; k < reps; k++)
                    send_frame(next_stamp(), step_height(0),
                               12'($urandom_range(1400, 600)));
                sent += reps;
                reps = $urandom_range(30, 8);
                for (k = 0; k < reps; k++)
                begin
                    if ($urandom_range(99) < 15)
                        send_frame(next_stamp(), step_height(0),
                                   12'($urandom_range(2300, 1500)));
                    else
                        send_frame(next_stamp(), step_height(rate),
                                   12'($urandom_range(2500, 900)));
                end
                sent += reps;
                reps = $urandom_range(6, 3);
                for (k = 0; k < reps; k++)
                    send_frame(next_stamp(), step_height(0),
                               12'($urandom_range(4095, 2600)));
                sent += reps;
            end
            else
            begin
                reps = $urandom_range(5, 1);
                for (k = 0; k < reps; k++)
                begin
                    gen_height = $signed(16'($urandom()));
                    gen_stamp  = $urandom();
                    send_frame(gen_stamp, gen_height[15:0], 12'($urandom_range(4095)));
                end
                sent += reps;
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------------

    // Field extremes, the first frame, short, zero, backward and huge
    // intervals, and a hand-made repetition through the phases.
    task automatic test_directed();
        int k;
        send_frame(32'd0, 16'sd32767, 12'd4095);
        send_frame(32'd1, -16'sd32768, 12'd0);
        send_frame(32'd1, 16'sd0, 12'd4095);
        send_frame(32'd0, 16'sd32767, 12'd0);
        send_frame(32'hFFFF_FFFF, -16'sd32768, 12'd2560);
        send_frame(32'h8000_0000, 16'sd32767, 12'd2559);
        send_frame(32'h8000_0002, -16'sd32768, 12'd100);
        send_frame(32'h8000_0004, 16'sd32767, 12'd100);
        gen_stamp  = 32'd100000;
        gen_height = 0;
        for (k = 0; k < 6; k++)
            send_frame(gen_stamp + 32'(33 * k), 16'(-400 * k), 12'd1200);
        for (k = 6; k < 10; k++)
            send_frame(gen_stamp + 32'(33 * k), -16'sd2400, 12'd900);
        for (k = 10; k < 16; k++)
            send_frame(gen_stamp + 32'(33 * k), 16'(-2400 + 400 * (k - 10)), 12'd2000);
        for (k = 16; k < 20; k++)
            send_frame(gen_stamp + 32'(33 * k), 16'sd0, 12'd3000);
        gen_stamp = gen_stamp + 32'(33 * 20);
        drain_words();
    endtask

    // Every register at its extremes, including a hold count of zero.
    task automatic test_register_extremes();
        write_all(0, 4095, 1, 32767, -32768, 32767, -32768, 32767);
        run_lifts(40);
        write_all(8388607, 0, 255, -32768, 32767, -32768, 32767, -32768);
        run_lifts(40);
        write_all(205, 2560, 0, 1599, 3200, 1599, -15447, 5461);
        run_lifts(40);
    endtask

    // Random lifts under one idling pattern, with a register set drawn near
    // the nominal tuning. Halfway the sender stops until all words are back.
    task automatic test_random_lifts(int src_pct, int snk_pct, int n);
        src_idle_pct  = src_pct;
        snk_stall_pct = snk_pct;
        write_all($urandom_range(800, 50), $urandom_range(3000, 2000),
                  $urandom_range(5, 1), 1599 + $urandom_range(400) - 200,
                  3200 + $urandom_range(400) - 200, 1599 + $urandom_range(400) - 200,
                  -15447 + $urandom_range(400) - 200, 5461 + $urandom_range(400) - 200);
        run_lifts(n / 2);
        stop_sending();
        while (pending_words.size() != 0)
            @(posedge clk);
        run_lifts(n / 2);
    endtask

    // ------------------------------------------------------------------------
    // Sequence of tests.
    // ------------------------------------------------------------------------
    initial
    begin
        error_count      = 0;
        src_idle_pct     = 0;
        snk_stall_pct    = 0;
        gen_stamp        = '0;
        gen_height       = 0;
        rst_n            = 1'b0;
        in_ch.valid      = 1'b0;
        in_ch.stamp_ms   = '0;
        in_ch.hip_height = '0;
        in_ch.knee_deg   = '0;
        out_ch.ready     = 1'b0;
        cfg_ch.valid     = 1'b0;
        cfg_ch.index     = REG_VEL_DEADBAND;
        cfg_ch.data      = '0;
        restore_defaults();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_register_extremes();
        test_random_lifts(0, 0, 200);
        test_random_lifts(80, 0, 200);
        test_random_lifts(0, 80, 200);
        test_random_lifts(35, 35, 200);

        drain_words();
        if (error_count == 0)
            $display("PASS lift_phase_detector");
        else
            $display("FAIL lift_phase_detector");
        $finish;
    end
endmodule
`default_nettype wire

[lift_phase_detector.f]
+incdir+design
design/lpd_pkg.sv
design/lpd_if.sv
design/lpd_mac.sv
design/lpd_div.sv
design/lift_phase_detector.sv
tb/sv/lift_phase_detector_test.sv
